// ===== sv/fspa_pkg.sv =====
// Shared types, codes and constants for the fixed slot pool allocator.
package fspa_pkg;

    // Field and register widths
    localparam int ACT_W    = 2;
    localparam int SIZE_W   = 32;
    localparam int ADDR_W   = 48;
    localparam int CNT_W    = 8;
    localparam int STAT_W   = 2;
    localparam int IDXO_W   = 7;
    localparam int CFGIDX_W = 2;
    localparam int CFG_W    = 48;

    // Default number of slot entries in the size memory
    localparam int SLOTS_DEF = 128;

    // Register reset values
    localparam logic [ADDR_W-1:0] POOL_BASE_RST  = '0;
    localparam logic [SIZE_W-1:0] POOL_BYTES_RST = 32'd65536;
    localparam logic [CNT_W-1:0]  SLOT_COUNT_RST = 8'd128;

    // Configuration register indexes
    localparam logic [CFGIDX_W-1:0] CFG_POOL_BASE  = 2'd0;
    localparam logic [CFGIDX_W-1:0] CFG_POOL_BYTES = 2'd1;
    localparam logic [CFGIDX_W-1:0] CFG_SLOT_COUNT = 2'd2;

    // Action codes; the unused code behaves as locate
    localparam logic [ACT_W-1:0] ACT_ALLOC   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LOCATE  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd2;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_FREE = 2'd1;
    localparam logic [STAT_W-1:0] ST_NULL    = 2'd2;
    localparam logic [STAT_W-1:0] ST_OUTSIDE = 2'd3;

    // Divider status towards the controller
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ===== sv/fspa_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module fspa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write on enable, read every cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/fspa_div.sv =====
// Radix-2 restoring divider: one quotient bit per cycle.
module fspa_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [fspa_pkg::SIZE_W-1:0] i_dividend,
    input  logic [fspa_pkg::SIZE_W-1:0] i_divisor,
    output fspa_pkg::t_div_stat        o_stat,
    output logic [fspa_pkg::SIZE_W-1:0] o_quotient,
    output logic [fspa_pkg::SIZE_W-1:0] o_remainder
);
    import fspa_pkg::*;

    localparam int STEP_W = $clog2(SIZE_W);

    logic [SIZE_W-1:0] r_quo;
    logic [SIZE_W-1:0] r_rem;
    logic [SIZE_W-1:0] r_dvs;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic              r_done;
    logic [SIZE_W:0]   rem_sh;
    logic [SIZE_W:0]   diff;

    // Shift in the next dividend bit and try the subtraction
    always_comb begin
        rem_sh = {r_rem, r_quo[SIZE_W-1]};
        diff   = rem_sh - {1'b0, r_dvs};
    end

    // Hold operands and step once per cycle while busy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
                r_step <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (!diff[SIZE_W]) begin
                    r_rem <= diff[SIZE_W-1:0];
                    r_quo <= {r_quo[SIZE_W-2:0], 1'b1};
                end else begin
                    r_rem <= rem_sh[SIZE_W-1:0];
                    r_quo <= {r_quo[SIZE_W-2:0], 1'b0};
                end
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(SIZE_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

// ===== sv/fixed_slot_pool_allocator.sv =====
// Fixed slot pool allocator: controller, slot size memory and shared divider.
// One transaction at a time. Locate and release go from acceptance to result
// through dispatch, a divider pass, memory read, multiply and output.
// Allocate scans the slots in order and stops at the first free one or when all are taken.
// After a configuration write the next transaction first recomputes the stride.
// Synchronous reset starts a clearing pass over all SLOTS entries with s_axis_tready low.
module fixed_slot_pool_allocator #(
    parameter int SLOTS = fspa_pkg::SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration write port
    input  logic                          i_cfg_we,
    input  logic [fspa_pkg::CFGIDX_W-1:0] i_cfg_index,
    input  logic [fspa_pkg::CFG_W-1:0]    i_cfg_data,
    // Request stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [79:0]                   s_axis_tdata,  // request_size[31:0], address[79:32]
    input  logic [fspa_pkg::ACT_W-1:0]    s_axis_tuser,  // action[1:0]
    // Result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [87:0]                   m_axis_tdata,  // slot_index[6:0], slot_address[54:7],
                                                         // aligned[55], stored_size[87:56]
    output logic [fspa_pkg::STAT_W-1:0]   m_axis_tuser   // status[1:0]
);
    import fspa_pkg::*;

    localparam int IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int NMAX = (SLOTS < 255) ? SLOTS : 255;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_PREP, S_STRIDE, S_SCAN, S_QDIV, S_LOOK, S_LDATA, S_MULT, S_OUT
    } t_state;

    t_state r_state;

    // Configuration
    logic [ADDR_W-1:0] r_pool_base;
    logic [SIZE_W-1:0] r_pool_bytes;
    logic [CNT_W-1:0]  r_slot_count;
    logic [SIZE_W-1:0] r_stride;
    logic              r_stride_ok;

    // Transaction in flight
    logic [ACT_W-1:0]  r_action;
    logic [SIZE_W-1:0] r_req;
    logic [ADDR_W-1:0] r_addr;
    logic [CNT_W-1:0]  r_ptr;
    logic [CNT_W-1:0]  r_chk;
    logic              r_chk_vld;
    logic [CNT_W-1:0]  r_idx;
    logic              r_al;
    logic [SIZE_W-1:0] r_size;
    logic [STAT_W-1:0] r_status;
    logic [39:0]       r_prod;
    logic [IW-1:0]     r_clr;

    // Output register
    logic              r_out_valid;
    logic [STAT_W-1:0] r_out_status;
    logic [IDXO_W-1:0] r_out_idx;
    logic [ADDR_W-1:0] r_out_addr;
    logic              r_out_al;
    logic [SIZE_W-1:0] r_out_size;

    // Datapath
    logic [CNT_W-1:0]  used_cnt;
    logic [ADDR_W:0]   off_full;
    logic              off_big;
    logic              ram_we;
    logic [IW-1:0]     ram_waddr;
    logic [SIZE_W-1:0] ram_wdata;
    logic [IW-1:0]     ram_raddr;
    logic [SIZE_W-1:0] ram_rdata;
    logic              div_start;
    logic [SIZE_W-1:0] div_a;
    logic [SIZE_W-1:0] div_b;
    t_div_stat         div_stat;
    logic [SIZE_W-1:0] div_quo;
    logic [SIZE_W-1:0] div_rem;

    // Limit the slot count to the memory depth
    assign used_cnt = (r_slot_count > CNT_W'(NMAX)) ? CNT_W'(NMAX) : r_slot_count;

    // Offset into the pool; the borrow bit flags an address below the base
    assign off_full = {1'b0, r_addr} - {1'b0, r_pool_base};
    assign off_big  = (off_full[ADDR_W-1:SIZE_W] != '0) ||
                      (off_full[SIZE_W-1:0] >= r_pool_bytes);

    // Divider launch: stride first, then the address offset
    always_comb begin
        div_start = 1'b0;
        div_a     = r_pool_bytes;
        div_b     = SIZE_W'(used_cnt);
        if (r_state == S_PREP) begin
            if (!r_stride_ok) begin
                div_start = (used_cnt != '0);
            end else if (r_action != ACT_ALLOC && r_addr != '0 && !off_full[ADDR_W] &&
                         r_stride != '0 && !off_big) begin
                div_start = 1'b1;
                div_a     = off_full[SIZE_W-1:0];
                div_b     = r_stride;
            end
        end
    end

    // Memory port selection: clearing pass, allocation, release
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = IW'(r_idx);
        ram_wdata = '0;
        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
            end
            S_SCAN: begin
                ram_we    = r_chk_vld && (ram_rdata == '0);
                ram_waddr = IW'(r_chk);
                ram_wdata = r_req;
            end
            S_LDATA: begin
                ram_we    = (r_action == ACT_RELEASE) && r_al;
            end
            default: begin
                ram_we    = 1'b0;
            end
        endcase
        ram_raddr = (r_state == S_SCAN) ? IW'(r_ptr) : IW'(r_idx);
    end

    fspa_ram #(
        .WIDTH (SIZE_W),
        .DEPTH (SLOTS)
    ) u_size_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    fspa_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_a),
        .i_divisor   (div_b),
        .o_stat      (div_stat),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // Controller: state, configuration and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_pool_base  <= POOL_BASE_RST;
            r_pool_bytes <= POOL_BYTES_RST;
            r_slot_count <= SLOT_COUNT_RST;
            r_stride_ok  <= 1'b0;
            r_chk_vld    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            // Take configuration writes; any change makes the stride stale
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_POOL_BASE:  r_pool_base  <= i_cfg_data;
                    CFG_POOL_BYTES: r_pool_bytes <= i_cfg_data[SIZE_W-1:0];
                    CFG_SLOT_COUNT: r_slot_count <= i_cfg_data[CNT_W-1:0];
                    default: ;
                endcase
                r_stride_ok <= 1'b0;
            end

            // Drop the result once the downstream side takes it
            if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == IW'(SLOTS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_action <= s_axis_tuser;
                        r_req    <= s_axis_tdata[SIZE_W-1:0];
                        r_addr   <= s_axis_tdata[SIZE_W +: ADDR_W];
                        r_state  <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_idx     <= '0;
                    r_al      <= 1'b0;
                    r_size    <= '0;
                    r_prod    <= '0;
                    r_ptr     <= '0;
                    r_chk_vld <= 1'b0;
                    if (!r_stride_ok) begin
                        if (used_cnt == '0) begin
                            r_stride    <= '0;
                            r_stride_ok <= 1'b1;
                        end else begin
                            r_state <= S_STRIDE;
                        end
                    end else if (r_action == ACT_ALLOC) begin
                        r_state <= S_SCAN;
                    end else if (r_addr == '0) begin
                        r_status <= ST_NULL;
                        r_state  <= S_OUT;
                    end else if (off_full[ADDR_W] || r_stride == '0 || off_big) begin
                        r_status <= ST_OUTSIDE;
                        r_state  <= S_OUT;
                    end else begin
                        r_state <= S_QDIV;
                    end
                end
                S_STRIDE: begin
                    if (div_stat.done) begin
                        r_stride    <= div_quo;
                        r_stride_ok <= 1'b1;
                        r_state     <= S_PREP;
                    end
                end
                S_SCAN: begin
                    // Issue one read per cycle, check the one issued before
                    r_ptr     <= r_ptr + 1'b1;
                    r_chk     <= r_ptr;
                    r_chk_vld <= (r_ptr < used_cnt);
                    if (r_chk_vld && ram_rdata == '0) begin
                        r_status <= ST_OK;
                        r_idx    <= r_chk;
                        r_al     <= 1'b1;
                        r_size   <= r_req;
                        r_state  <= S_MULT;
                    end else if (r_ptr >= used_cnt) begin
                        r_status <= ST_NO_FREE;
                        r_state  <= S_OUT;
                    end
                end
                S_QDIV: begin
                    if (div_stat.done) begin
                        if (div_quo >= SIZE_W'(used_cnt)) begin
                            r_status <= ST_OUTSIDE;
                            r_state  <= S_OUT;
                        end else begin
                            r_status <= ST_OK;
                            r_idx    <= div_quo[CNT_W-1:0];
                            r_al     <= (div_rem == '0);
                            r_state  <= S_LOOK;
                        end
                    end
                end
                S_LOOK: begin
                    r_state <= S_LDATA;
                end
                S_LDATA: begin
                    r_size  <= ram_rdata;
                    r_state <= S_MULT;
                end
                S_MULT: begin
                    r_prod  <= 40'(r_idx) * 40'(r_stride);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_status;
                        r_out_idx    <= r_idx[IDXO_W-1:0];
                        r_out_addr   <= (r_status == ST_OK) ?
                                        r_pool_base + ADDR_W'(r_prod) : '0;
                        r_out_al     <= r_al;
                        r_out_size   <= r_size;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_size, r_out_al, r_out_addr, r_out_idx};
    assign m_axis_tuser  = r_out_status;

    // The size memory is never written between transactions
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !ram_we)
        else $error("size memory written while idle");

    // An error result carries zero index, address, size and alignment
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != ST_OK) |->
            (r_out_addr == '0 && r_out_size == '0 && !r_out_al && r_out_idx == '0))
        else $error("error result with nonzero fields");

    // The divider is only launched when free
    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider launched while busy");

    // An accepted transaction is dispatched next
    a_accept_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state == S_PREP))
        else $error("accepted transaction not dispatched");

    // A new result is only loaded when the previous one is gone or taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_out_valid && !m_axis_tready) |=> $stable(r_out_size))
        else $error("pending result overwritten");

endmodule
